// ===== hdl/dclq_pkg.sv =====
// dclq_pkg: shared types, sizes and codes for the dual class linked queue
// used by dual_class_linked_queue and its port checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dclq_pkg;

    // handle field width and the number of handle slots it spans
    localparam int HANDLE_W    = 6;
    localparam int NUM_HANDLES = 2 ** HANDLE_W;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    // stream word widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    // operation codes
    localparam t_mode MODE_PUSH     = 3'd0;
    localparam t_mode MODE_POP_PHYS = 3'd1;
    localparam t_mode MODE_POP_VIRT = 3'd2;
    localparam t_mode MODE_REMOVE   = 3'd3;
    localparam t_mode MODE_QUERY    = 3'd4;

    // result status codes
    localparam t_status STAT_OK               = 2'd0;
    localparam t_status STAT_PUSH_QUEUED      = 2'd1;
    localparam t_status STAT_POP_EMPTY        = 2'd2;
    localparam t_status STAT_REMOVE_UNQUEUED  = 2'd3;

    // queue classes
    localparam logic CLASS_PHYS = 1'b0;
    localparam logic CLASS_VIRT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // one result word
    typedef struct packed {
        t_status status;
        logic    all_empty;
        t_handle virt_head_handle;
        logic    virt_head_valid;
        t_handle phys_head_handle;
        logic    phys_head_valid;
        t_handle popped_handle;
        logic    popped_valid;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/dual_class_linked_queue.sv =====
// dual_class_linked_queue: two fifo queues of handles kept as doubly linked
// lists in synchronous link memories; depends on dclq_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel  | dir | handshake                         | payload
//  ---------+-----+-----------------------------------+------------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready | tdata: mode, handle; tuser: is_virtual
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready | tdata: one result word
//
//  each word passes an accept cycle and an execute cycle: the accept cycle issues
//  the link and class memory reads, the execute cycle uses the registered read
//  data, writes the memories back and loads the result register; the synchronous
//  link memory reads set this split. a result waiting in the output register does
//  not block the next accept; only the execute step waits for the register to free.
//  reset (synchronous, active low) clears the queued flags, both queue pointers
//  and the handshake state at once; the link memories need no clearing.

module dual_class_linked_queue (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input word
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [2:0] mode, [8:3] handle, [15:9] zero
    input  wire  [dclq_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // [0] is_virtual
    input  wire                                  i_s_axis_tuser,
    // result word
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // [0] popped_valid, [6:1] popped_handle, [7] phys_head_valid,
    // [13:8] phys_head_handle, [14] virt_head_valid, [20:15] virt_head_handle,
    // [21] all_empty, [23:22] status
    output logic [dclq_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    // ---------------------------------------------------------------------
    // state
    // ---------------------------------------------------------------------
    dclq_pkg::t_state   r_state, n_state;

    // per queue pointers, index 0 physical, index 1 virtual
    dclq_pkg::t_handle  r_head [2];
    dclq_pkg::t_handle  r_tail [2];
    logic [1:0]         r_ne;
    dclq_pkg::t_handle  n_head [2];
    dclq_pkg::t_handle  n_tail [2];
    logic [1:0]         n_ne;

    // queued flags, one per handle, cleared by reset
    logic [dclq_pkg::NUM_HANDLES-1:0] r_queued, n_queued;

    // link and class memories, contents undefined until written
    dclq_pkg::t_handle  r_next_mem  [dclq_pkg::NUM_HANDLES];
    dclq_pkg::t_handle  r_prev_mem  [dclq_pkg::NUM_HANDLES];
    logic               r_class_mem [dclq_pkg::NUM_HANDLES];

    // registered read data
    dclq_pkg::t_handle  r_rd_next;
    dclq_pkg::t_handle  r_rd_prev;
    logic               r_rd_class;

    // latched input word
    dclq_pkg::t_mode    r_mode;
    dclq_pkg::t_handle  r_handle;
    logic               r_cls;

    // output register
    logic               r_out_valid;
    dclq_pkg::t_result  r_out;
    dclq_pkg::t_result  n_out;

    // ---------------------------------------------------------------------
    // handshake control
    // ---------------------------------------------------------------------
    logic               w_in_accept;
    logic               w_exec;
    logic               w_out_free;

    dclq_pkg::t_mode    w_in_mode;
    dclq_pkg::t_handle  w_in_handle;
    dclq_pkg::t_handle  w_rd_addr;

    assign w_in_mode   = i_s_axis_tdata[dclq_pkg::MODE_W-1:0];
    assign w_in_handle = i_s_axis_tdata[dclq_pkg::MODE_W +: dclq_pkg::HANDLE_W];

    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dclq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_exec          = 1'b0;
        unique case (r_state)
            dclq_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = dclq_pkg::ST_EXEC;
                end
            end
            dclq_pkg::ST_EXEC: begin
                // hold the word until the result register can take it
                if (w_out_free) begin
                    w_exec  = 1'b1;
                    n_state = dclq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dclq_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // read side: a pop reads the links of its queue head, anything else
    // reads at the handle
    // ---------------------------------------------------------------------
    always_comb begin
        if (w_in_mode == dclq_pkg::MODE_POP_PHYS) begin
            w_rd_addr = r_head[0];
        end else if (w_in_mode == dclq_pkg::MODE_POP_VIRT) begin
            w_rd_addr = r_head[1];
        end else begin
            w_rd_addr = w_in_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_rd_next  <= r_next_mem[w_rd_addr];
            r_rd_prev  <= r_prev_mem[w_rd_addr];
            r_rd_class <= r_class_mem[w_rd_addr];
            r_mode     <= w_in_mode;
            r_handle   <= w_in_handle;
            r_cls      <= i_s_axis_tuser;
        end
    end

    // ---------------------------------------------------------------------
    // execute: list update and write back
    // ---------------------------------------------------------------------
    logic               c_wr_next_en;
    dclq_pkg::t_handle  c_wr_next_addr;
    dclq_pkg::t_handle  c_wr_next_data;
    logic               c_wr_prev_en;
    dclq_pkg::t_handle  c_wr_prev_addr;
    dclq_pkg::t_handle  c_wr_prev_data;
    logic               c_wr_class_en;

    always_comb begin
        logic               q;
        dclq_pkg::t_handle  top;
        logic               pv;
        dclq_pkg::t_handle  ph;
        dclq_pkg::t_status  st;

        n_head         = r_head;
        n_tail         = r_tail;
        n_ne           = r_ne;
        n_queued       = r_queued;
        c_wr_next_en   = 1'b0;
        c_wr_next_addr = r_handle;
        c_wr_next_data = r_handle;
        c_wr_prev_en   = 1'b0;
        c_wr_prev_addr = r_handle;
        c_wr_prev_data = r_handle;
        c_wr_class_en  = 1'b0;
        q              = dclq_pkg::CLASS_PHYS;
        top            = r_handle;
        pv             = 1'b0;
        ph             = '0;
        st             = dclq_pkg::STAT_OK;

        case (r_mode) inside
            dclq_pkg::MODE_PUSH: begin
                q = r_cls;
                if (r_queued[r_handle]) begin
                    st = dclq_pkg::STAT_PUSH_QUEUED;
                end else begin
                    if (r_ne[q]) begin
                        // append behind the current tail
                        c_wr_next_en   = 1'b1;
                        c_wr_next_addr = r_tail[q];
                        c_wr_next_data = r_handle;
                        c_wr_prev_en   = 1'b1;
                        c_wr_prev_addr = r_handle;
                        c_wr_prev_data = r_tail[q];
                        n_tail[q]      = r_handle;
                    end else begin
                        n_head[q] = r_handle;
                        n_tail[q] = r_handle;
                        n_ne[q]   = 1'b1;
                    end
                    n_queued[r_handle] = 1'b1;
                    c_wr_class_en      = 1'b1;
                end
            end
            dclq_pkg::MODE_POP_PHYS, dclq_pkg::MODE_POP_VIRT: begin
                q = (r_mode == dclq_pkg::MODE_POP_VIRT);
                if (r_ne[q]) begin
                    top = r_head[q];
                    pv  = 1'b1;
                    ph  = top;
                    if (r_tail[q] == top) begin
                        n_ne[q] = 1'b0;
                    end else begin
                        n_head[q] = r_rd_next;
                    end
                    n_queued[top] = 1'b0;
                end else begin
                    st = dclq_pkg::STAT_POP_EMPTY;
                end
            end
            dclq_pkg::MODE_REMOVE: begin
                q = r_rd_class;
                if (!r_queued[r_handle]) begin
                    st = dclq_pkg::STAT_REMOVE_UNQUEUED;
                end else begin
                    if (r_head[q] == r_handle) begin
                        if (r_tail[q] == r_handle) begin
                            n_ne[q] = 1'b0;
                        end else begin
                            n_head[q] = r_rd_next;
                        end
                    end else if (r_tail[q] == r_handle) begin
                        n_tail[q] = r_rd_prev;
                    end else begin
                        // middle of the list: bridge the neighbours
                        c_wr_next_en   = 1'b1;
                        c_wr_next_addr = r_rd_prev;
                        c_wr_next_data = r_rd_next;
                        c_wr_prev_en   = 1'b1;
                        c_wr_prev_addr = r_rd_next;
                        c_wr_prev_data = r_rd_prev;
                    end
                    n_queued[r_handle] = 1'b0;
                end
            end
            default: begin
                // query and unused codes change nothing
            end
        endcase

        n_out.popped_valid     = pv;
        n_out.popped_handle    = ph;
        n_out.phys_head_valid  = n_ne[0];
        n_out.phys_head_handle = n_ne[0] ? n_head[0] : '0;
        n_out.virt_head_valid  = n_ne[1];
        n_out.virt_head_handle = n_ne[1] ? n_head[1] : '0;
        n_out.all_empty        = !n_ne[0] && !n_ne[1];
        n_out.status           = st;
    end

    // memory write ports, one per store
    always_ff @(posedge i_clk) begin
        if (w_exec && c_wr_next_en) begin
            r_next_mem[c_wr_next_addr] <= c_wr_next_data;
        end
        if (w_exec && c_wr_prev_en) begin
            r_prev_mem[c_wr_prev_addr] <= c_wr_prev_data;
        end
        if (w_exec && c_wr_class_en) begin
            r_class_mem[r_handle] <= r_cls;
        end
    end

    // queue pointers and queued flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_tail[0] <= '0;
            r_tail[1] <= '0;
            r_ne      <= '0;
            r_queued  <= '0;
        end else if (w_exec) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_ne     <= n_ne;
            r_queued <= n_queued;
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// ===== hdl/dclq_checker.sv =====
// dclq_checker: port level checks on dual_class_linked_queue, bound to it below
// depends on dclq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dclq_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_axis_tvalid,
    input  wire                             o_s_axis_tready,
    input  wire                             o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    input  wire [dclq_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    dclq_pkg::t_result w_res;
    assign w_res = o_m_axis_tdata;

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // one word in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted during execute");

    // empty flag agrees with both head flags
    a_all_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (w_res.all_empty == (!w_res.phys_head_valid && !w_res.virt_head_valid)))
        else $error("all_empty disagrees with head flags");

    // heads of empty queues read as zero
    a_empty_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((w_res.phys_head_valid || w_res.phys_head_handle == '0) &&
             (w_res.virt_head_valid || w_res.virt_head_handle == '0)))
        else $error("empty queue shows a nonzero head");

    // a pop that returned a handle reports success; otherwise the popped handle reads as zero
    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (w_res.popped_valid ? (w_res.status == dclq_pkg::STAT_OK)
                                : (w_res.popped_handle == '0)))
        else $error("popped fields inconsistent with status");

endmodule

bind dual_class_linked_queue dclq_checker u_dclq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
